[rtl/core/mhtq_pkg.sv]
// Shared types, constants and helpers of the min-heap timer queue.
package mhtq_pkg;

  localparam int HEAP_CAPACITY = 32;
  localparam int NUM_IDS       = 64;
  localparam int MAX_RESULTS   = 32;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 6;
  localparam int TIME_W = 32;
  localparam int STAT_W = 2;

  localparam int NUM_LEVELS = $clog2(HEAP_CAPACITY + 1);
  localparam int LVL_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int TOP_SLOTS  = HEAP_CAPACITY - (2 ** (NUM_LEVELS - 1)) + 1;
  localparam int FULL_SLOTS = (NUM_LEVELS > 1) ? 2 ** (NUM_LEVELS - 2) : 1;
  localparam int LVL_SLOTS  = (TOP_SLOTS > FULL_SLOTS) ? TOP_SLOTS : FULL_SLOTS;
  localparam int ROWS       = (LVL_SLOTS + 1) / 2;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W      = ROW_W + 1;
  localparam int CNT_W      = $clog2(HEAP_CAPACITY + 1);
  localparam int SLOT_W     = NUM_LEVELS + 2;
  localparam int RES_W      = $clog2(MAX_RESULTS + 1);
  localparam int FLAG_W     = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_FIRED    = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUP,
    S_RESP,
    S_TCHK,
    S_SDN
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [ID_W-1:0]   id;
  } ent_t;

  // two siblings of one level
  typedef ent_t [1:0] row_t;

  // moving hole: level-local index and the entry being placed
  typedef struct packed {
    logic             valid;
    logic             up;
    logic [IDX_W-1:0] idx;
    ent_t             ent;
  } tok_t;

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [IDX_W-1:0] idx;
  } loc_t;

  // heap slot number to level and index within level
  function automatic loc_t slot_loc(input logic [CNT_W-1:0] s);
    logic [CNT_W:0] v;
    loc_t           r;
    v = (CNT_W + 1)'(s) + (CNT_W + 1)'(1);
    r = '0;
    for (int b = 0; b <= CNT_W; b++) begin
      if (v[b]) begin
        r.lvl = LVL_W'(b);
      end
    end
    r.idx = IDX_W'(v - ((CNT_W + 1)'(1) << r.lvl));
    return r;
  endfunction

endpackage

[rtl/core/mhtq_if.sv]
// Item channels of the timer queue: command in, result out.
interface mhtq_req_if;
  logic                             valid;
  logic                             ready;
  logic [mhtq_pkg::CMD_W-1:0]       cmd;
  logic [mhtq_pkg::ID_W-1:0]        timer_id;
  logic [mhtq_pkg::TIME_W-1:0]      expire_time;
  logic [mhtq_pkg::TIME_W-1:0]      now;

  modport source (output valid, cmd, timer_id, expire_time, now, input ready);
  modport sink   (input valid, cmd, timer_id, expire_time, now, output ready);
endinterface

interface mhtq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mhtq_pkg::STAT_W-1:0] status;
  logic [mhtq_pkg::ID_W-1:0]   fired_id;
  logic                        last;

  modport source (output valid, status, fired_id, last, input ready);
  modport sink   (input valid, status, fired_id, last, output ready);
endinterface

[rtl/core/mhtq_cell.sv]
// One heap level: its slots and one step of sift-up or sift-down for a hole held here.
module mhtq_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [mhtq_pkg::LVL_W-1:0]     lvl,
  input  logic [mhtq_pkg::CNT_W-1:0]     cnt,
  input  mhtq_pkg::tok_t                 inj,
  input  mhtq_pkg::tok_t                 from_up,
  input  mhtq_pkg::tok_t                 from_dn,
  output mhtq_pkg::tok_t                 to_up,
  output mhtq_pkg::tok_t                 to_dn,
  input  logic [mhtq_pkg::ROW_W-1:0]     rd_row,
  output mhtq_pkg::row_t                 rd_data,
  input  mhtq_pkg::row_t                 nb_up,
  input  mhtq_pkg::row_t                 nb_dn,
  output logic [mhtq_pkg::ROW_W-1:0]     req_up,
  output logic [mhtq_pkg::ROW_W-1:0]     req_dn,
  output logic                           done
);

  mhtq_pkg::tok_t                    tok;
  mhtq_pkg::row_t                    mem [mhtq_pkg::ROWS];

  logic                              wr_en;
  logic [mhtq_pkg::ROW_W-1:0]        wr_row;
  logic                              wr_sel;
  mhtq_pkg::ent_t                    wr_ent;
  logic [mhtq_pkg::IDX_W-1:0]        par_idx;
  mhtq_pkg::ent_t                    par;
  logic [mhtq_pkg::SLOT_W-1:0]       cl_slot;
  logic [mhtq_pkg::SLOT_W-1:0]       cr_slot;
  logic                              go_l;
  logic                              go_r;
  logic [mhtq_pkg::TIME_W-1:0]       best_exp;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= mhtq_pkg::tok_t'(inj | from_up | from_dn);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_sel] <= wr_ent;
    end
  end

  assign rd_data = mem[rd_row];

  always_comb begin
    par_idx  = tok.idx >> 1;
    par      = nb_up[par_idx[0]];
    cl_slot  = (mhtq_pkg::SLOT_W'(2) << lvl) - mhtq_pkg::SLOT_W'(1)
               + (mhtq_pkg::SLOT_W'(tok.idx) << 1);
    cr_slot  = cl_slot + mhtq_pkg::SLOT_W'(1);
    go_l     = (cl_slot < mhtq_pkg::SLOT_W'(cnt)) && (nb_dn[0].expiry < tok.ent.expiry);
    best_exp = go_l ? nb_dn[0].expiry : tok.ent.expiry;
    go_r     = (cr_slot < mhtq_pkg::SLOT_W'(cnt)) && (nb_dn[1].expiry < best_exp);

    wr_en  = 1'b0;
    wr_row = tok.idx[mhtq_pkg::IDX_W-1:1];
    wr_sel = tok.idx[0];
    wr_ent = tok.ent;
    to_up  = '0;
    to_dn  = '0;
    req_up = '0;
    req_dn = '0;
    done   = 1'b0;

    if (tok.valid) begin
      wr_en = 1'b1;
      if (tok.up) begin
        req_up = par_idx[mhtq_pkg::IDX_W-1:1];
        if (lvl != '0 && par.expiry > tok.ent.expiry) begin
          wr_ent = par;
          to_up  = '{valid: 1'b1, up: 1'b1, idx: par_idx, ent: tok.ent};
        end else begin
          done = 1'b1;
        end
      end else begin
        req_dn = tok.idx[mhtq_pkg::ROW_W-1:0];
        if (go_l || go_r) begin
          wr_ent = go_r ? nb_dn[1] : nb_dn[0];
          to_dn  = '{valid: 1'b1, up: 1'b0,
                     idx: {tok.idx[mhtq_pkg::IDX_W-2:0], go_r}, ent: tok.ent};
        end else begin
          done = 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/min_heap_timer_queue.sv]
// Timer queue: binary min-heap of expiry times kept as a chain of level cells.
//
// Commands arrive on req (valid/ready); results leave on rsp (valid/ready).
// An item is taken when valid and ready are both high at a clock edge.
// add: the entry enters at the first free slot and a hole walks up the chain of
//   level cells, one level per cycle; one result, accepted or full.
// cancel: sets the ID's cancelled flag; one result, accepted.
// tick: pops every entry due at or before now, each pop a check step plus the
//   walk of the sift-down hole through the level cells; up to 32
//   fired results, each item of rsp carrying one ID, last set on the final one;
//   nothing expired when no ID fires. Command 3 gives no result.
// The sift walk moves through the level cells one level per cycle; a new command
//   is taken only when idle.
// A single output register parts the two sides: a stalled receiver holds the
//   work at the next result, and a command can be taken while a result waits.
// Reset (synchronous, rst high) empties the heap and clears all cancelled
//   flags at once; heap slots are not cleared.
module min_heap_timer_queue (
  input  logic         clk,
  input  logic         rst,
  mhtq_req_if.sink     req,
  mhtq_rsp_if.source   rsp
);

  localparam int NL = mhtq_pkg::NUM_LEVELS;

  mhtq_pkg::state_t                state, state_next;
  logic [mhtq_pkg::CNT_W-1:0]      count, count_next;
  logic [mhtq_pkg::NUM_IDS-1:0]    canc, canc_next;
  logic [mhtq_pkg::RES_W-1:0]      nres, nres_next;
  logic                            pend, pend_next;
  logic [mhtq_pkg::ID_W-1:0]       pend_id, pend_id_next;
  logic [mhtq_pkg::TIME_W-1:0]     now_q, now_q_next;
  mhtq_pkg::status_t               resp_st, resp_st_next;
  logic                            out_valid, out_valid_next;
  mhtq_pkg::status_t               out_st, out_st_next;
  logic [mhtq_pkg::ID_W-1:0]       out_fid, out_fid_next;
  logic                            out_last, out_last_next;

  logic                            inj_en;
  mhtq_pkg::loc_t                  inj_loc;
  mhtq_pkg::tok_t                  inj_tok;
  logic                            rd_en;
  mhtq_pkg::loc_t                  rd_loc;
  logic                            out_free;
  logic                            done_any;
  logic                            id_ok;
  logic                            top_ok;
  logic                            dead;
  mhtq_pkg::ent_t                  root;
  mhtq_pkg::ent_t                  last_ent;

  mhtq_pkg::tok_t                  inj_a   [NL];
  mhtq_pkg::tok_t                  to_up_a [NL];
  mhtq_pkg::tok_t                  to_dn_a [NL];
  mhtq_pkg::row_t                  rdat    [NL];
  logic [mhtq_pkg::ROW_W-1:0]      crd     [NL];
  logic [mhtq_pkg::ROW_W-1:0]      rq_up   [NL];
  logic [mhtq_pkg::ROW_W-1:0]      rq_dn   [NL];
  logic [NL-1:0]                   done_v;

  for (genvar L = 0; L < NL; L++) begin : g_lvl
    mhtq_pkg::tok_t              f_up;
    mhtq_pkg::tok_t              f_dn;
    mhtq_pkg::row_t              n_up;
    mhtq_pkg::row_t              n_dn;
    logic [mhtq_pkg::ROW_W-1:0]  r_up;
    logic [mhtq_pkg::ROW_W-1:0]  r_dn;

    if (L == 0) begin : g_first
      assign f_up = '0;
      assign n_up = '0;
      assign r_up = '0;
    end else begin : g_mid_up
      assign f_up = to_dn_a[L-1];
      assign n_up = rdat[L-1];
      assign r_up = rq_dn[L-1];
    end

    if (L == NL - 1) begin : g_final
      assign f_dn = '0;
      assign n_dn = '0;
      assign r_dn = '0;
    end else begin : g_mid_dn
      assign f_dn = to_up_a[L+1];
      assign n_dn = rdat[L+1];
      assign r_dn = rq_up[L+1];
    end

    assign inj_a[L] = (inj_en && inj_loc.lvl == mhtq_pkg::LVL_W'(L)) ? inj_tok : '0;
    assign crd[L]   = (rd_en && rd_loc.lvl == mhtq_pkg::LVL_W'(L))
                      ? rd_loc.idx[mhtq_pkg::IDX_W-1:1] : '0;

    mhtq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .lvl     (mhtq_pkg::LVL_W'(L)),
      .cnt     (count),
      .inj     (inj_a[L]),
      .from_up (f_up),
      .from_dn (f_dn),
      .to_up   (to_up_a[L]),
      .to_dn   (to_dn_a[L]),
      .rd_row  (crd[L] | r_up | r_dn),
      .rd_data (rdat[L]),
      .nb_up   (n_up),
      .nb_dn   (n_dn),
      .req_up  (rq_up[L]),
      .req_dn  (rq_dn[L]),
      .done    (done_v[L])
    );
  end

  assign done_any     = |done_v;
  assign root         = rdat[0][0];
  assign last_ent     = rdat[rd_loc.lvl][rd_loc.idx[0]];
  assign out_free     = !out_valid || rsp.ready;
  assign id_ok        = (9'(req.timer_id) < 9'(mhtq_pkg::NUM_IDS));
  assign top_ok       = (9'(root.id) < 9'(mhtq_pkg::NUM_IDS));
  assign dead         = top_ok && canc[mhtq_pkg::FLAG_W'(root.id)];

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_st;
  assign rsp.fired_id = out_fid;
  assign rsp.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhtq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      canc      <= '0;
      nres      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      canc      <= canc_next;
      nres      <= nres_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
    pend_id  <= pend_id_next;
    now_q    <= now_q_next;
    resp_st  <= resp_st_next;
    out_st   <= out_st_next;
    out_fid  <= out_fid_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    canc_next      = canc;
    nres_next      = nres;
    pend_next      = pend;
    pend_id_next   = pend_id;
    now_q_next     = now_q;
    resp_st_next   = resp_st;
    out_valid_next = out_valid && !rsp.ready;
    out_st_next    = out_st;
    out_fid_next   = out_fid;
    out_last_next  = out_last;
    req.ready      = (state == mhtq_pkg::S_IDLE);
    inj_en         = 1'b0;
    inj_loc        = mhtq_pkg::slot_loc(count);
    inj_tok        = '0;
    rd_en          = 1'b0;
    rd_loc         = mhtq_pkg::slot_loc(count - mhtq_pkg::CNT_W'(1));

    case (state)
      mhtq_pkg::S_IDLE: begin
        if (req.valid) begin
          case (req.cmd)
            mhtq_pkg::CMD_ADD: begin
              if (count == mhtq_pkg::CNT_W'(mhtq_pkg::HEAP_CAPACITY)) begin
                resp_st_next = mhtq_pkg::ST_FULL;
                state_next   = mhtq_pkg::S_RESP;
              end else begin
                inj_en       = 1'b1;
                inj_tok      = '{valid: 1'b1, up: 1'b1, idx: inj_loc.idx,
                                 ent: '{expiry: req.expire_time, id: req.timer_id}};
                count_next   = count + mhtq_pkg::CNT_W'(1);
                if (id_ok) begin
                  canc_next[mhtq_pkg::FLAG_W'(req.timer_id)] = 1'b0;
                end
                resp_st_next = mhtq_pkg::ST_ACCEPTED;
                state_next   = mhtq_pkg::S_SUP;
              end
            end
            mhtq_pkg::CMD_CANCEL: begin
              if (id_ok) begin
                canc_next[mhtq_pkg::FLAG_W'(req.timer_id)] = 1'b1;
              end
              resp_st_next = mhtq_pkg::ST_ACCEPTED;
              state_next   = mhtq_pkg::S_RESP;
            end
            mhtq_pkg::CMD_TICK: begin
              now_q_next = req.now;
              nres_next  = '0;
              pend_next  = 1'b0;
              state_next = mhtq_pkg::S_TCHK;
            end
            default: begin
              state_next = mhtq_pkg::S_IDLE;
            end
          endcase
        end
      end

      mhtq_pkg::S_SUP: begin
        if (done_any) begin
          state_next = mhtq_pkg::S_RESP;
        end
      end

      mhtq_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_st_next    = resp_st;
          out_fid_next   = '0;
          out_last_next  = 1'b1;
          state_next     = mhtq_pkg::S_IDLE;
        end
      end

      mhtq_pkg::S_TCHK: begin
        if (out_free) begin
          if (count != '0 && nres < mhtq_pkg::RES_W'(mhtq_pkg::MAX_RESULTS)
              && root.expiry <= now_q) begin
            count_next = count - mhtq_pkg::CNT_W'(1);
            if (count > mhtq_pkg::CNT_W'(1)) begin
              // last entry fills the root hole and sinks
              rd_en      = 1'b1;
              inj_en     = 1'b1;
              inj_loc    = '0;
              inj_tok    = '{valid: 1'b1, up: 1'b0, idx: '0, ent: last_ent};
              state_next = mhtq_pkg::S_SDN;
            end
            if (!dead) begin
              if (pend) begin
                out_valid_next = 1'b1;
                out_st_next    = mhtq_pkg::ST_FIRED;
                out_fid_next   = pend_id;
                out_last_next  = 1'b0;
              end
              pend_next    = 1'b1;
              pend_id_next = root.id;
              nres_next    = nres + mhtq_pkg::RES_W'(1);
            end
          end else begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            if (pend) begin
              out_st_next  = mhtq_pkg::ST_FIRED;
              out_fid_next = pend_id;
            end else begin
              out_st_next  = mhtq_pkg::ST_NONE;
              out_fid_next = '0;
            end
            pend_next  = 1'b0;
            state_next = mhtq_pkg::S_IDLE;
          end
        end
      end

      mhtq_pkg::S_SDN: begin
        if (done_any) begin
          state_next = mhtq_pkg::S_TCHK;
        end
      end

      default: begin
        state_next = mhtq_pkg::S_IDLE;
      end
    endcase
  end

endmodule
